// File: hdl/pcsb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcsb_pkg: shared types and constants
// Command codes, widths and table constants for the per-class budget table.
// ----------------------------------------------------------------------------
package pcsb_pkg;
    localparam int TableDepthDefault = 16;
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_RESET = 2'd1;
    localparam logic [1:0] CMD_FIT   = 2'd2;
    localparam logic [31:0] UNLIMITED = 32'hFFFF_FFFF;
    localparam logic [31:0] LOW_MARK = 32'd10;

    typedef logic [15:0] key_t;
    typedef logic [31:0] size_t;
    typedef logic [16:0] ratio_t;

    // operation carried along the chain
    typedef struct packed {
        logic         go;
        logic         load;
        logic         rst_budget;
        logic         fit;
        logic         found;
        logic         accept;
        logic         full;
        key_t         key;
        size_t        limit;
        ratio_t       ratio;
        size_t        fit_size;
        logic [48:0]  packed_shift;
        logic [32:0]  den;
        size_t        total;
    } op_t;
endpackage
`default_nettype wire

// File: hdl/pcsb_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcsb_cell: one table entry
// Holds one entry; serves load, budget reset and fit as the item passes by,
// adds its share to the running total and hands the item to the next cell.
// ----------------------------------------------------------------------------
module pcsb_cell
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire pcsb_pkg::op_t op_in,
    output pcsb_pkg::op_t      op_out
);
    import pcsb_pkg::*;

    key_t   key_reg;
    size_t  max_reg;
    ratio_t ratio_reg;
    size_t  rem_reg, rem_next;
    logic   valid_reg, valid_next;
    op_t    op_reg, op_next;
    logic [49:0] rhs;
    logic   ratio_bad;
    logic   match;
    logic   take_load;
    size_t  rem_less;

    assign take_load  = op_in.go && op_in.load && !valid_reg;
    assign match      = op_in.go && op_in.fit && valid_reg && !op_in.found
                        && (key_reg == op_in.key);
    assign rhs        = {33'd0, ratio_reg} * {17'd0, op_in.den};
    assign ratio_bad  = {1'b0, op_in.packed_shift} > rhs;
    assign rem_less   = rem_reg - op_in.fit_size;
    assign valid_next = valid_reg || take_load;
    assign op_out     = op_reg;

    always_comb
    begin
        rem_next     = rem_reg;
        op_next      = op_in;
        op_next.load = op_in.load && !take_load;
        if (take_load)
        begin
            rem_next = op_in.limit;
        end
        if (op_in.go && op_in.rst_budget && valid_reg)
        begin
            rem_next = max_reg;
        end
        if (match)
        begin
            op_next.found = 1'b1;
            if (!ratio_bad)
            begin
                if (rem_reg == UNLIMITED)
                begin
                    op_next.accept = 1'b1;
                end
                else if (rem_reg >= op_in.fit_size)
                begin
                    op_next.accept = 1'b1;
                    rem_next       = rem_less;
                end
            end
        end
        if (op_in.go && valid_next && rem_next != UNLIMITED)
        begin
            op_next.total = op_in.total + {rem_next[30:0], 1'b0}
                            + ((rem_next < LOW_MARK) ? LOW_MARK : '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            op_reg    <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            op_reg    <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_load)
        begin
            key_reg   <= op_in.key;
            max_reg   <= op_in.limit;
            ratio_reg <= op_in.ratio;
        end
        rem_reg <= rem_next;
    end
endmodule
`default_nettype wire

// File: hdl/per_class_size_budget_table_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// per_class_size_budget_table_top: per-class size budget table
// An accepted item passes through the TABLE_DEPTH cell registers in turn and
// then the result register; one item at a time: in_stall holds off a new item
// until the result has been accepted at the output, so output stall delays it.
// Reset clears the entry count, valid bits, highest ratio and handshakes.
// ----------------------------------------------------------------------------
module per_class_size_budget_table_top
#(
    parameter int TABLE_DEPTH = pcsb_pkg::TableDepthDefault
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  command,
    input  wire logic [15:0] class_key,
    input  wire logic [31:0] size_limit,
    input  wire logic [16:0] ratio_limit,
    input  wire logic [31:0] raw_size,
    input  wire logic [31:0] packed_size,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             accepted,
    output logic             key_found,
    output logic             table_full,
    output logic [31:0]      limited_total,
    output logic [16:0]      highest_ratio
);
    import pcsb_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic          busy_reg, busy_next;
    logic [CW-1:0] count_reg;
    ratio_t        hr_reg;
    logic          in_acc;
    logic          out_acc;
    logic          full;
    logic          acc_reg, fnd_reg, full_reg;
    size_t         total_reg;
    op_t           op_first;
    op_t           op_c [TABLE_DEPTH+1];

    assign in_stall = busy_reg;
    assign in_acc   = in_valid && !busy_reg;
    assign out_acc  = out_valid && !out_stall;
    assign full     = count_reg >= CW'(TABLE_DEPTH);
    assign op_c[0]  = op_first;

    always_comb
    begin
        op_first              = '0;
        op_first.go           = in_acc;
        op_first.load         = (command == CMD_LOAD) && !full;
        op_first.rst_budget   = command == CMD_RESET;
        op_first.fit          = command == CMD_FIT;
        op_first.accept       = (command == CMD_LOAD) && !full;
        op_first.full         = (command == CMD_LOAD) && full;
        op_first.key          = class_key;
        op_first.limit        = size_limit;
        op_first.ratio        = ratio_limit;
        op_first.fit_size     = (packed_size != '0) ? packed_size : raw_size;
        op_first.packed_shift = {1'b0, packed_size, 16'd0};
        op_first.den          = (raw_size != '0) ? {1'b0, raw_size} : 33'd1;
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            pcsb_cell u_cell
            (
                .clk(clk), .rst_n(rst_n),
                .op_in(op_c[g]), .op_out(op_c[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        busy_next = busy_reg;
        if (in_acc)
        begin
            busy_next = 1'b1;
        end
        else if (out_acc)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            out_valid <= 1'b0;
            count_reg <= '0;
            hr_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (op_c[TABLE_DEPTH].go)
            begin
                out_valid <= 1'b1;
            end
            else if (out_acc)
            begin
                out_valid <= 1'b0;
            end
            if (in_acc && command == CMD_LOAD && !full)
            begin
                count_reg <= count_reg + 1'b1;
                if (ratio_limit > hr_reg)
                begin
                    hr_reg <= ratio_limit;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_c[TABLE_DEPTH].go)
        begin
            acc_reg   <= op_c[TABLE_DEPTH].accept;
            fnd_reg   <= op_c[TABLE_DEPTH].found;
            full_reg  <= op_c[TABLE_DEPTH].full;
            total_reg <= op_c[TABLE_DEPTH].total;
        end
    end

    assign accepted      = acc_reg;
    assign key_found     = fnd_reg;
    assign table_full    = full_reg;
    assign limited_total = total_reg;
    assign highest_ratio = hr_reg;

    a_noacc: assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_acc)
        else $error("item accepted while result pending");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH)) else $error("entry count overflow");
    a_outbusy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> busy_reg) else $error("result without item");
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> ##(TABLE_DEPTH + 1) out_valid) else $error("result late");
endmodule
`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: per-class size budget table
// Drives load, budget reset, fit and code 3 items with random gaps and output
// stalls, predicts every result from a behavioral table, checks each field.
// ----------------------------------------------------------------------------
module testbench;
    import pcsb_pkg::*;

    localparam int DEPTH = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] class_key;
        logic [31:0] size_limit;
        logic [16:0] ratio_limit;
        logic [31:0] raw_size;
        logic [31:0] packed_size;
    } request_t;

    typedef struct packed {
        logic        accepted;
        logic        key_found;
        logic        table_full;
        logic [31:0] limited_total;
        logic [16:0] highest_ratio;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] command = CMD_LOAD;
    logic [15:0] class_key = '0;
    logic [31:0] size_limit = '0;
    logic [16:0] ratio_limit = '0;
    logic [31:0] raw_size = '0;
    logic [31:0] packed_size = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic accepted;
    logic key_found;
    logic table_full;
    logic [31:0] limited_total;
    logic [16:0] highest_ratio;

    request_t pending_items[$];
    verdict_t expected_verdicts[$];
    int in_gap = 0;
    int out_gap = 0;
    int idle_cycles = 0;
    int failures = 0;
    bit stimulus_done = 1'b0;

    logic [15:0] tbl_key[DEPTH];
    logic [31:0] tbl_max[DEPTH];
    logic [16:0] tbl_ratio[DEPTH];
    logic [31:0] tbl_left[DEPTH];
    int tbl_count = 0;
    logic [16:0] top_ratio = '0;

    per_class_size_budget_table_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .class_key(class_key), .size_limit(size_limit),
        .ratio_limit(ratio_limit), .raw_size(raw_size), .packed_size(packed_size),
        .out_valid(out_valid), .out_stall(out_stall),
        .accepted(accepted), .key_found(key_found), .table_full(table_full),
        .limited_total(limited_total), .highest_ratio(highest_ratio)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 30);
    endfunction

    function automatic logic [31:0] budget_total();
        logic [31:0] sum;
        sum = '0;
        for (int i = 0; i < tbl_count; i++)
        begin
            if (tbl_left[i] != UNLIMITED)
            begin
                sum = sum + (tbl_left[i] << 1);
                if (tbl_left[i] < LOW_MARK)
                    sum = sum + LOW_MARK;
            end
        end
        return sum;
    endfunction

    function automatic verdict_t apply_request(request_t rq);
        verdict_t v;
        logic [63:0] lhs;
        logic [63:0] rhs;
        logic [31:0] need;
        v = '0;
        if (rq.command == CMD_LOAD)
        begin
            if (tbl_count >= DEPTH)
                v.table_full = 1'b1;
            else
            begin
                tbl_key[tbl_count] = rq.class_key;
                tbl_max[tbl_count] = rq.size_limit;
                tbl_ratio[tbl_count] = rq.ratio_limit;
                tbl_left[tbl_count] = rq.size_limit;
                tbl_count++;
                if (rq.ratio_limit > top_ratio)
                    top_ratio = rq.ratio_limit;
                v.accepted = 1'b1;
            end
        end
        else if (rq.command == CMD_RESET)
        begin
            for (int i = 0; i < tbl_count; i++)
                tbl_left[i] = tbl_max[i];
        end
        else if (rq.command == CMD_FIT)
        begin
            for (int i = 0; i < tbl_count; i++)
            begin
                if (tbl_key[i] == rq.class_key)
                begin
                    v.key_found = 1'b1;
                    lhs = {16'd0, rq.packed_size, 16'd0};
                    rhs = 64'(tbl_ratio[i]) * 64'((rq.raw_size != 0) ? rq.raw_size : 32'd1);
                    need = (rq.packed_size != 0) ? rq.packed_size : rq.raw_size;
                    if (rq.packed_size != 0 && lhs > rhs)
                        v.accepted = 1'b0;
                    else if (tbl_left[i] == UNLIMITED)
                        v.accepted = 1'b1;
                    else if (tbl_left[i] >= need)
                    begin
                        tbl_left[i] = tbl_left[i] - need;
                        v.accepted = 1'b1;
                    end
                    break;
                end
            end
        end
        v.limited_total = budget_total();
        v.highest_ratio = top_ratio;
        return v;
    endfunction

    function automatic request_t make_item(logic [1:0] c, logic [15:0] k, logic [31:0] lim,
                                           logic [16:0] rat, logic [31:0] raw,
                                           logic [31:0] pk);
        request_t rq;
        rq.command = c;
        rq.class_key = k;
        rq.size_limit = lim;
        rq.ratio_limit = rat;
        rq.raw_size = raw;
        rq.packed_size = pk;
        return rq;
    endfunction

    task automatic add_item(request_t rq);
        pending_items.insert(pending_items.size(), rq);
    endtask

    function automatic logic [31:0] rand_size();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return $urandom_range(0, 40);
        else if (r < 7)
            return $urandom_range(0, 5000);
        else if (r < 8)
            return UNLIMITED;
        else
            return $urandom;
    endfunction

    function automatic logic [16:0] rand_ratio();
        int r;
        r = $urandom_range(0, 4);
        if (r == 0)
            return 17'h1FFFF;
        else if (r == 1)
            return 17'h10000;
        else
            return 17'($urandom);
    endfunction

    initial
    begin
        int n;
        logic [15:0] k;
        add_item(make_item(CMD_FIT, 16'h0000, 0, 0, 5, 0));
        add_item(make_item(CMD_RESET, 16'hFFFF, 0, 0, 0, 0));
        add_item(make_item(CMD_LOAD, 16'h0000, 32'd25, 17'h10000, 0, 0));
        add_item(make_item(CMD_LOAD, 16'hFFFF, UNLIMITED, 17'h1FFFF, 0, 0));
        add_item(make_item(CMD_LOAD, 16'h0001, 32'd0, 17'h00000, 0, 0));
        add_item(make_item(CMD_LOAD, 16'h0000, 32'hFFFF_FFFE, 17'h08000, 0, 0));
        add_item(make_item(CMD_FIT, 16'h0000, 0, 0, 32'd20, 0));
        add_item(make_item(CMD_FIT, 16'h0000, 0, 0, 32'd20, 0));
        add_item(make_item(CMD_FIT, 16'h0000, 0, 0, 32'd0, 32'd1));
        add_item(make_item(CMD_FIT, 16'h0000, 0, 0, 32'd4, 32'd4));
        add_item(make_item(CMD_FIT, 16'hFFFF, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        add_item(make_item(CMD_FIT, 16'hFFFF, 0, 0, 32'd0, 32'hFFFF_FFFF));
        add_item(make_item(CMD_FIT, 16'h0001, 0, 0, 32'd0, 0));
        add_item(make_item(CMD_FIT, 16'h1234, 0, 0, 32'd1, 0));
        add_item(make_item(2'd3, 16'hFFFF, 32'hFFFF_FFFF, 17'h1FFFF,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF));
        add_item(make_item(CMD_RESET, 16'h0000, 0, 0, 0, 0));
        for (int i = 0; i < 13; i++)
            add_item(make_item(CMD_LOAD, 16'(i + 2), 32'(i), rand_ratio(), 0, 0));
        add_item(make_item(CMD_FIT, 16'h000E, 0, 0, 32'd1, 32'd1));
        for (int i = 0; i < 1500; i++)
        begin
            n = $urandom_range(0, 99);
            k = 16'($urandom_range(0, 7));
            if ($urandom_range(0, 19) == 0)
                k = 16'($urandom);
            if (n < 4)
                add_item(make_item(CMD_RESET, 16'($urandom), $urandom,
                                   17'($urandom), $urandom, $urandom));
            else if (n < 6)
                add_item(make_item(2'd3, 16'($urandom), $urandom,
                                   17'($urandom), $urandom, $urandom));
            else if (n < 9)
            begin
                add_item(make_item(CMD_RESET, 0, 0, 0, 0, 0));
                add_item(make_item(CMD_LOAD, k, rand_size(), rand_ratio(),
                                   $urandom, $urandom));
            end
            else if (n < 14)
                add_item(make_item(CMD_LOAD, k, rand_size(), rand_ratio(),
                                   $urandom, $urandom));
            else
                add_item(make_item(CMD_FIT, k, $urandom, 17'($urandom),
                                   rand_size(),
                                   ($urandom_range(0, 1) == 0) ? 32'd0 : rand_size()));
            if ($urandom_range(0, 299) == 0)
            begin
                for (int j = 0; j < 3; j++)
                    add_item(make_item(CMD_RESET, 0, 0, 0, 0, 0));
            end
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver
    always @(posedge clk)
    begin
        request_t rq;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                rq = {command, class_key, size_limit, ratio_limit, raw_size, packed_size};
                expected_verdicts.insert(expected_verdicts.size(), apply_request(rq));
                in_gap = pick_gap();
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_valid <= 1'b0;
                    in_gap--;
                end
                else if (pending_items.size() > 0)
                begin
                    rq = pending_items.pop_front();
                    in_valid <= 1'b1;
                    command <= rq.command;
                    class_key <= rq.class_key;
                    size_limit <= rq.size_limit;
                    ratio_limit <= rq.ratio_limit;
                    raw_size <= rq.raw_size;
                    packed_size <= rq.packed_size;
                end
                else
                begin
                    in_valid <= 1'b0;
                    stimulus_done = 1'b1;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        verdict_t got;
        verdict_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = {accepted, key_found, table_full, limited_total, highest_ratio};
                if (expected_verdicts.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, got);
                    failures++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (got.accepted !== want.accepted)
                    begin
                        $display("%0t: accepted expected %b actual %b", $time,
                                 want.accepted, got.accepted);
                        failures++;
                    end
                    if (got.key_found !== want.key_found)
                    begin
                        $display("%0t: key_found expected %b actual %b", $time,
                                 want.key_found, got.key_found);
                        failures++;
                    end
                    if (got.table_full !== want.table_full)
                    begin
                        $display("%0t: table_full expected %b actual %b", $time,
                                 want.table_full, got.table_full);
                        failures++;
                    end
                    if (got.limited_total !== want.limited_total)
                    begin
                        $display("%0t: limited_total expected %h actual %h", $time,
                                 want.limited_total, got.limited_total);
                        failures++;
                    end
                    if (got.highest_ratio !== want.highest_ratio)
                    begin
                        $display("%0t: highest_ratio expected %h actual %h", $time,
                                 want.highest_ratio, got.highest_ratio);
                        failures++;
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_stall <= 1'b1;
                out_gap--;
            end
            else
            begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 3) == 0)
                    out_gap = pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (rst_n);
        while (!(stimulus_done && expected_verdicts.size() == 0) &&
               idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
        else
        begin
            repeat (20) @(posedge clk);
            if (failures == 0)
                $display("testbench passed");
            else
                $display("testbench failed");
            $finish;
        end
    end
endmodule
